### hw/rtl/asoc_pkg.sv
package asoc_pkg;

  localparam int unsigned GYRO_W      = 16;
  localparam int unsigned HEIGHT_W    = 24;
  localparam int unsigned ELAPSED_W   = 8;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned TIMER_W     = 17;
  localparam int unsigned PHASE_W     = 3;
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned NUM_LANES   = 3;

  localparam int unsigned LANE_X = 0;
  localparam int unsigned LANE_Z = 1;
  localparam int unsigned LANE_H = 2;

  localparam int unsigned MAX_SAMPLES_DEF = 4095;

  localparam logic [TIME_W-1:0] WARM_TIME_RST  = TIME_W'(6000);
  localparam logic [TIME_W-1:0] CALIB_TIME_RST = TIME_W'(3000);

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE  = 3'd0,
    PH_WARM  = 3'd1,
    PH_CALIB = 3'd2,
    PH_WAIT  = 3'd3,
    PH_DONE  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_DIV,
    CTL_FIN
  } ctl_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WARM_TIME  = 4'd0,
    REG_CALIB_TIME = 4'd1
  } reg_e;

  typedef struct packed {
    logic                         restart;
    logic [ELAPSED_W-1:0]         elapsed_ms;
    logic                         switch_level;
    logic signed [GYRO_W-1:0]     gyro_x;
    logic signed [GYRO_W-1:0]     gyro_z;
    logic signed [HEIGHT_W-1:0]   height;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0]           phase;
    logic                         offsets_ready;
    logic                         start_request;
    logic signed [GYRO_W-1:0]     offset_x;
    logic signed [GYRO_W-1:0]     offset_z;
    logic signed [HEIGHT_W-1:0]   zero_height;
  } out_item_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [TIME_W-1:0]     wdata;
  } cfg_item_t;

endpackage

### hw/rtl/asoc_if.sv
interface asoc_in_if;
  logic               valid;
  logic               ready;
  asoc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asoc_out_if;
  logic                valid;
  logic                ready;
  asoc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asoc_cfg_if;
  logic                valid;
  logic                ready;
  asoc_pkg::cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/armed_sensor_offset_calibrator.sv
// An accepted beat's result is registered and valid in the cycle after it, except
// the beat that ends calibration: the three averages come from bit-serial restoring
// dividers, one quotient bit per cycle; no beat is taken while they run.
// Throughput: one beat per cycle while results are taken; the result register frees
// the input side as soon as it drains. Reset (async, active low) returns idle phase,
// clears timer, sums, count and held offsets, and reloads warm 6000 / calib 3000 ms.
module armed_sensor_offset_calibrator #(
  parameter int unsigned MAX_SAMPLES = asoc_pkg::MAX_SAMPLES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  asoc_in_if.sink    in_i,
  asoc_out_if.source out_o,
  asoc_cfg_if.sink   cfg_i
);

  localparam int unsigned CntW    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumGW   = asoc_pkg::GYRO_W + CntW;
  localparam int unsigned SumHW   = asoc_pkg::HEIGHT_W + CntW;
  localparam int unsigned ItW     = $clog2(SumHW);
  localparam int unsigned TW      = asoc_pkg::TIMER_W;

  // configuration
  logic [asoc_pkg::TIME_W-1:0] warm_q, calib_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q  <= asoc_pkg::WARM_TIME_RST;
      calib_q <= asoc_pkg::CALIB_TIME_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.addr)
        asoc_pkg::REG_WARM_TIME:  warm_q  <= cfg_i.data.wdata;
        asoc_pkg::REG_CALIB_TIME: calib_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  asoc_pkg::phase_e         phase_q, phase_d;
  logic [TW-1:0]            timer_q, timer_d;
  logic signed [SumGW-1:0]  sum_x_q, sum_x_d, sum_z_q, sum_z_d;
  logic signed [SumHW-1:0]  sum_h_q, sum_h_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic signed [asoc_pkg::GYRO_W-1:0]   held_x_q, held_z_q;
  logic signed [asoc_pkg::HEIGHT_W-1:0] held_h_q;
  logic                     start_req, div_start;

  asoc_pkg::ctl_e           ctl_q, ctl_d;
  logic [ItW-1:0]           iter_q;
  logic [SumHW-1:0]         mag_q [asoc_pkg::NUM_LANES];
  logic [SumHW-1:0]         mag_nx [asoc_pkg::NUM_LANES];
  logic [SumHW-1:0]         mag_ld [asoc_pkg::NUM_LANES];
  logic [CntW-1:0]          rem_q [asoc_pkg::NUM_LANES];
  logic [CntW-1:0]          rem_nx [asoc_pkg::NUM_LANES];
  logic                     neg_q [asoc_pkg::NUM_LANES];
  logic                     neg_ld [asoc_pkg::NUM_LANES];
  logic                     div_last, in_fire, in_rdy;

  logic                     out_valid_q, out_valid_d;
  asoc_pkg::out_item_t      out_q, out_d;
  logic [SumHW-1:0]         quot [asoc_pkg::NUM_LANES];

  assign in_fire = in_i.valid && in_rdy;

  // timer advance, saturating
  logic [TW:0]   timer_sum;
  logic [TW-1:0] timer_adv;
  assign timer_sum = {1'b0, timer_q} + (TW+1)'(in_i.data.elapsed_ms);
  assign timer_adv = timer_sum[TW] ? {TW{1'b1}} : timer_sum[TW-1:0];

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    sum_x_d   = sum_x_q;
    sum_z_d   = sum_z_q;
    sum_h_d   = sum_h_q;
    cnt_d     = cnt_q;
    start_req = 1'b0;
    div_start = 1'b0;
    if (in_i.data.restart) begin
      phase_d = asoc_pkg::PH_IDLE;
      timer_d = '0;
    end else begin
      case (phase_q)
        asoc_pkg::PH_WARM: begin
          timer_d = timer_adv;
          if (timer_adv >= TW'(warm_q)) begin
            phase_d = asoc_pkg::PH_CALIB;
            sum_x_d = '0;
            sum_z_d = '0;
            sum_h_d = '0;
            cnt_d   = '0;
            timer_d = '0;
          end
        end
        asoc_pkg::PH_CALIB: begin
          timer_d = timer_adv;
          if (timer_adv >= TW'(calib_q)) begin
            phase_d   = asoc_pkg::PH_WAIT;
            div_start = 1'b1;
          end else if (cnt_q < CntW'(MAX_SAMPLES)) begin
            sum_x_d = sum_x_q + SumGW'(in_i.data.gyro_x);
            sum_z_d = sum_z_q + SumGW'(in_i.data.gyro_z);
            sum_h_d = sum_h_q + SumHW'(in_i.data.height);
            cnt_d   = cnt_q + CntW'(1);
          end
        end
        asoc_pkg::PH_WAIT: begin
          if (in_i.data.switch_level) begin
            phase_d   = asoc_pkg::PH_DONE;
            start_req = 1'b1;
          end
        end
        asoc_pkg::PH_DONE: ;
        default: begin
          phase_d = asoc_pkg::PH_IDLE;
          if (in_i.data.switch_level) begin
            phase_d = asoc_pkg::PH_WARM;
            timer_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= asoc_pkg::PH_IDLE;
      timer_q <= '0;
      sum_x_q <= '0;
      sum_z_q <= '0;
      sum_h_q <= '0;
      cnt_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      sum_x_q <= sum_x_d;
      sum_z_q <= sum_z_d;
      sum_h_q <= sum_h_d;
      cnt_q   <= cnt_d;
    end
  end

  // divider lanes: sign/magnitude, restoring, one quotient bit per cycle
  logic signed [SumHW-1:0] ext_x, ext_z;
  assign ext_x = SumHW'(sum_x_q);
  assign ext_z = SumHW'(sum_z_q);

  always_comb begin
    neg_ld[asoc_pkg::LANE_X] = ext_x[SumHW-1];
    neg_ld[asoc_pkg::LANE_Z] = ext_z[SumHW-1];
    neg_ld[asoc_pkg::LANE_H] = sum_h_q[SumHW-1];
    mag_ld[asoc_pkg::LANE_X] = ext_x[SumHW-1] ? -ext_x : ext_x;
    mag_ld[asoc_pkg::LANE_Z] = ext_z[SumHW-1] ? -ext_z : ext_z;
    mag_ld[asoc_pkg::LANE_H] = sum_h_q[SumHW-1] ? -sum_h_q : sum_h_q;
  end

  always_comb begin
    logic [CntW:0] sh;
    logic          ge;
    for (int l = 0; l < asoc_pkg::NUM_LANES; l++) begin
      sh        = {rem_q[l], mag_q[l][SumHW-1]};
      ge        = sh >= {1'b0, cnt_q};
      rem_nx[l] = ge ? CntW'(sh - {1'b0, cnt_q}) : sh[CntW-1:0];
      mag_nx[l] = {mag_q[l][SumHW-2:0], ge};
      quot[l]   = (cnt_q == '0) ? '0 : (neg_q[l] ? -mag_q[l] : mag_q[l]);
    end
  end

  assign div_last = (iter_q == ItW'(SumHW - 1));

  // control: next state
  always_comb begin
    ctl_d = ctl_q;
    case (ctl_q)
      asoc_pkg::CTL_IDLE: if (in_fire && div_start) ctl_d = asoc_pkg::CTL_DIV;
      asoc_pkg::CTL_DIV:  if (div_last) ctl_d = asoc_pkg::CTL_FIN;
      asoc_pkg::CTL_FIN:  ctl_d = asoc_pkg::CTL_IDLE;
      default:            ctl_d = asoc_pkg::CTL_IDLE;
    endcase
  end

  // control: outputs
  always_comb begin
    case (ctl_q)
      asoc_pkg::CTL_IDLE: in_rdy = !out_valid_q || out_o.ready;
      default:            in_rdy = 1'b0;
    endcase
  end

  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= asoc_pkg::CTL_IDLE;
      iter_q <= '0;
    end else begin
      ctl_q <= ctl_d;
      if (ctl_q == asoc_pkg::CTL_DIV) iter_q <= iter_q + ItW'(1);
      else                            iter_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < asoc_pkg::NUM_LANES; l++) begin
      if (in_fire && div_start) begin
        mag_q[l] <= mag_ld[l];
        rem_q[l] <= '0;
        neg_q[l] <= neg_ld[l];
      end else if (ctl_q == asoc_pkg::CTL_DIV) begin
        mag_q[l] <= mag_nx[l];
        rem_q[l] <= rem_nx[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q <= '0;
      held_z_q <= '0;
      held_h_q <= '0;
    end else if (ctl_q == asoc_pkg::CTL_FIN) begin
      held_x_q <= quot[asoc_pkg::LANE_X][asoc_pkg::GYRO_W-1:0];
      held_z_q <= quot[asoc_pkg::LANE_Z][asoc_pkg::GYRO_W-1:0];
      held_h_q <= quot[asoc_pkg::LANE_H][asoc_pkg::HEIGHT_W-1:0];
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    if (ctl_q == asoc_pkg::CTL_FIN) begin
      out_valid_d         = 1'b1;
      out_d.phase         = asoc_pkg::PH_WAIT;
      out_d.offsets_ready = 1'b1;
      out_d.start_request = 1'b0;
      out_d.offset_x      = quot[asoc_pkg::LANE_X][asoc_pkg::GYRO_W-1:0];
      out_d.offset_z      = quot[asoc_pkg::LANE_Z][asoc_pkg::GYRO_W-1:0];
      out_d.zero_height   = quot[asoc_pkg::LANE_H][asoc_pkg::HEIGHT_W-1:0];
    end else if (in_fire && !div_start) begin
      out_valid_d         = 1'b1;
      out_d.phase         = phase_d;
      out_d.offsets_ready = 1'b0;
      out_d.start_request = start_req;
      out_d.offset_x      = held_x_q;
      out_d.offset_z      = held_z_q;
      out_d.zero_height   = held_h_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

### hw/rtl/asoc_checker.sv
module asoc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input asoc_pkg::out_item_t out_data_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  a_ready_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.offsets_ready |->
      out_data_i.phase == asoc_pkg::PH_WAIT && !out_data_i.start_request)
    else $error("offsets_ready outside calibrated-waiting phase");

  a_start_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.start_request |-> out_data_i.phase == asoc_pkg::PH_DONE)
    else $error("start_request outside handed-over phase");

  // the averaged beat comes out of the divider while the input is held off
  a_ready_after_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) && out_data_i.offsets_ready |-> $past(!in_ready_i))
    else $error("averaged result without input hold-off");

  a_result_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) && !out_data_i.offsets_ready |-> $past(in_valid_i && in_ready_i))
    else $error("result without an accepted beat");

endmodule

bind armed_sensor_offset_calibrator asoc_checker u_asoc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMER_MAX  = (1 << asoc_pkg::TIMER_W) - 1;
  localparam int unsigned DRAIN_WAIT = 48;  // margin for the slowest beat, the one that runs the dividers

  // Tracks the calibration sequence beat by beat and queues the report each pass produces.
  class calib_tracker;
    logic [asoc_pkg::TIME_W-1:0] warm_ms;
    logic [asoc_pkg::TIME_W-1:0] calib_ms;
    asoc_pkg::phase_e phase;
    int unsigned timer;
    longint sum_x;
    longint sum_z;
    longint sum_h;
    int unsigned count;
    logic signed [asoc_pkg::GYRO_W-1:0] held_x;
    logic signed [asoc_pkg::GYRO_W-1:0] held_z;
    logic signed [asoc_pkg::HEIGHT_W-1:0] held_h;
    asoc_pkg::out_item_t expected_reports[$];
    int unsigned mismatches;

    function new();
      warm_ms = asoc_pkg::WARM_TIME_RST;
      calib_ms = asoc_pkg::CALIB_TIME_RST;
      phase = asoc_pkg::PH_IDLE;
      timer = 0;
      sum_x = 0;
      sum_z = 0;
      sum_h = 0;
      count = 0;
      held_x = '0;
      held_z = '0;
      held_h = '0;
      mismatches = 0;
    endfunction

    function void set_time(asoc_pkg::reg_e idx, logic [asoc_pkg::TIME_W-1:0] ms);
      if (idx == asoc_pkg::REG_WARM_TIME) begin
        warm_ms = ms;
      end else if (idx == asoc_pkg::REG_CALIB_TIME) begin
        calib_ms = ms;
      end
    endfunction

    // truncates toward zero, zero samples give zero
    function longint mean(longint sum, int unsigned n);
      if (n == 0) return 0;
      return sum / longint'(n);
    endfunction

    function void take_pass(asoc_pkg::in_item_t it);
      asoc_pkg::out_item_t rep;
      bit ready_f;
      bit start_f;
      int unsigned stepped;
      ready_f = 1'b0;
      start_f = 1'b0;
      stepped = timer + it.elapsed_ms;
      if (stepped > TIMER_MAX) stepped = TIMER_MAX;
      if (it.restart) begin
        phase = asoc_pkg::PH_IDLE;
        timer = 0;
      end else begin
        case (phase)
          asoc_pkg::PH_WARM: begin
            timer = stepped;
            if (timer >= warm_ms) begin
              phase = asoc_pkg::PH_CALIB;
              sum_x = 0;
              sum_z = 0;
              sum_h = 0;
              count = 0;
              timer = 0;
            end
          end
          asoc_pkg::PH_CALIB: begin
            timer = stepped;
            if (timer >= calib_ms) begin
              held_x = asoc_pkg::GYRO_W'(mean(sum_x, count));
              held_z = asoc_pkg::GYRO_W'(mean(sum_z, count));
              held_h = asoc_pkg::HEIGHT_W'(mean(sum_h, count));
              phase = asoc_pkg::PH_WAIT;
              ready_f = 1'b1;
            end else if (count < asoc_pkg::MAX_SAMPLES_DEF) begin
              sum_x += $signed(it.gyro_x);
              sum_z += $signed(it.gyro_z);
              sum_h += $signed(it.height);
              count++;
            end
          end
          asoc_pkg::PH_WAIT: begin
            if (it.switch_level) begin
              phase = asoc_pkg::PH_DONE;
              start_f = 1'b1;
            end
          end
          asoc_pkg::PH_DONE: ;
          default: begin
            phase = asoc_pkg::PH_IDLE;
            if (it.switch_level) begin
              phase = asoc_pkg::PH_WARM;
              timer = 0;
            end
          end
        endcase
      end
      rep.phase = phase;
      rep.offsets_ready = ready_f;
      rep.start_request = start_f;
      rep.offset_x = held_x;
      rep.offset_z = held_z;
      rep.zero_height = held_h;
      expected_reports.push_back(rep);
    endfunction

    function void match_field(string name, logic signed [31:0] exp_v,
                              logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_report(asoc_pkg::out_item_t got);
      asoc_pkg::out_item_t exp_r;
      if (expected_reports.size() == 0) begin
        $error("report beat with nothing expected: phase %0d", got.phase);
        mismatches++;
        return;
      end
      exp_r = expected_reports.pop_front();
      match_field("phase", {29'd0, exp_r.phase}, {29'd0, got.phase});
      match_field("offsets_ready", {31'd0, exp_r.offsets_ready}, {31'd0, got.offsets_ready});
      match_field("start_request", {31'd0, exp_r.start_request}, {31'd0, got.start_request});
      match_field("offset_x", $signed(exp_r.offset_x), $signed(got.offset_x));
      match_field("offset_z", $signed(exp_r.offset_z), $signed(got.offset_z));
      match_field("zero_height", $signed(exp_r.zero_height), $signed(got.zero_height));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  asoc_in_if  in_if ();
  asoc_out_if out_if ();
  asoc_cfg_if cfg_if ();

  armed_sensor_offset_calibrator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  calib_tracker tracker = new();

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("armed_sensor_offset_calibrator: mismatch");
    $finish;
  end

  // report sink: random stalls plus an occasional long hold-off
  initial begin : report_sink
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      tracker.check_report(out_if.data);
    end
  end

  function automatic asoc_pkg::in_item_t mk_pass(bit rs, int el, bit sw, int gx, int gz,
                                                 int h);
    asoc_pkg::in_item_t it;
    it.restart = rs;
    it.elapsed_ms = asoc_pkg::ELAPSED_W'(el);
    it.switch_level = sw;
    it.gyro_x = asoc_pkg::GYRO_W'(gx);
    it.gyro_z = asoc_pkg::GYRO_W'(gz);
    it.height = asoc_pkg::HEIGHT_W'(h);
    return it;
  endfunction

  function automatic int rand_gyro();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      default: return $signed(asoc_pkg::GYRO_W'($urandom()));
    endcase
  endfunction

  function automatic int rand_height();
    case ($urandom_range(7))
      0: return -8388608;
      1: return 8388607;
      default: return $signed(asoc_pkg::HEIGHT_W'($urandom()));
    endcase
  endfunction

  // mostly walks the sequence forward; a little restart noise everywhere
  function automatic asoc_pkg::in_item_t rand_pass();
    int roll;
    int el;
    bit sw;
    bit rs;
    roll = $urandom_range(99);
    el = ($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
    sw = 1'($urandom_range(1));
    rs = (roll >= 97);
    case (tracker.phase)
      asoc_pkg::PH_IDLE: sw = (roll < 70);
      asoc_pkg::PH_DONE: rs = rs || (roll < 40);
      default: ;
    endcase
    return mk_pass(rs, el, sw, rand_gyro(), rand_gyro(), rand_height());
  endfunction

  int unsigned pick_ms;
  function automatic int unsigned pick_time();
    return ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 600);
  endfunction

  task automatic drive_pass(input asoc_pkg::in_item_t it);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    tracker.take_pass(it);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // both time registers, written back to back once the block is quiet
  task automatic load_times(input int unsigned warm, input int unsigned calib);
    asoc_pkg::cfg_item_t beat;
    settle();
    for (int i = 0; i < 2; i++) begin
      beat.addr = (i == 0) ? asoc_pkg::REG_WARM_TIME : asoc_pkg::REG_CALIB_TIME;
      beat.wdata = asoc_pkg::TIME_W'((i == 0) ? warm : calib);
      cfg_if.valid <= 1'b1;
      cfg_if.data <= beat;
      @(posedge clk_i);
      while (cfg_if.ready !== 1'b1) @(posedge clk_i);
      tracker.set_time(asoc_pkg::reg_e'(beat.addr), beat.wdata);
    end
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned gaps[4];
    int unsigned stalls[4];
    gaps = '{0, 68, 0, 36};
    stalls = '{0, 0, 68, 36};
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero times: each phase ends on its first pass, no samples taken
    load_times(0, 0);
    drive_pass(mk_pass(0, 0, 0, 5, 5, 5));
    drive_pass(mk_pass(1, 255, 1, -1, -1, -1));
    drive_pass(mk_pass(0, 255, 1, 32767, -32768, 8388607));
    drive_pass(mk_pass(0, 0, 0, 1, 1, 1));
    drive_pass(mk_pass(0, 0, 0, 1, 1, 1));
    drive_pass(mk_pass(0, 0, 0, 1, 1, 1));
    drive_pass(mk_pass(0, 0, 1, 1, 1, 1));
    drive_pass(mk_pass(0, 255, 1, 1, 1, 1));
    drive_pass(mk_pass(1, 0, 0, 1, 1, 1));

    // extreme samples; averages with negative sums truncate toward zero
    load_times(10, 255);
    drive_pass(mk_pass(0, 7, 1, 0, 0, 0));
    drive_pass(mk_pass(0, 255, 0, 0, 0, 0));
    drive_pass(mk_pass(0, 0, 0, -32768, 32767, -8388608));
    drive_pass(mk_pass(0, 0, 1, 32767, 32767, 8388607));
    drive_pass(mk_pass(0, 0, 0, -1, -32768, -2));
    drive_pass(mk_pass(0, 255, 0, 0, 0, 0));
    drive_pass(mk_pass(1, 255, 1, 0, 0, 0));
    // restart while warming, then while calibrating
    drive_pass(mk_pass(0, 0, 1, 0, 0, 0));
    drive_pass(mk_pass(0, 3, 0, 0, 0, 0));
    drive_pass(mk_pass(1, 0, 0, 0, 0, 0));
    drive_pass(mk_pass(0, 0, 1, 0, 0, 0));
    drive_pass(mk_pass(0, 255, 0, 0, 0, 0));
    drive_pass(mk_pass(0, 1, 1, 123, -456, 789));
    drive_pass(mk_pass(1, 255, 1, 0, 0, 0));

    // longest calibration window, extreme samples piling up in the sums
    load_times(0, 65535);
    drive_pass(mk_pass(0, 0, 1, 0, 0, 0));
    drive_pass(mk_pass(0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 20; i++) begin
      drive_pass(mk_pass(0, 0, 1'($urandom_range(1)), -32768, rand_gyro(),
                         ($urandom_range(1) != 0) ? 8388607 : rand_height()));
    end
    for (int i = 0; i < 260; i++) begin
      drive_pass(mk_pass(0, 255, 0, rand_gyro(), rand_gyro(), rand_height()));
    end
    drive_pass(mk_pass(1, 0, 0, 0, 0, 0));

    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        pick_ms = pick_time();
        load_times(pick_ms, pick_time());
        gap_pct = gaps[p];
        stall_pct = stalls[p];
        // long report hold-off while passes keep coming: input side must back up
        if (p == 2 && s == 0) hold_req = 300;
        for (int i = 0; i < 24; i++) drive_pass(rand_pass());
      end
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("armed_sensor_offset_calibrator: match");
    end else begin
      $display("armed_sensor_offset_calibrator: mismatch");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/asoc_pkg.sv
hw/rtl/asoc_if.sv
hw/rtl/armed_sensor_offset_calibrator.sv
hw/rtl/asoc_checker.sv
verif/testbench.sv
